/* rtl/tbps_pkg.sv */
// Shared widths, constants and register indexes for the transport beat phase source.
package tbps_pkg;

  // Default number of fraction bits in the time format
  localparam int FRAC_BITS_DEF = 24;

  // Field widths
  localparam int ELAPSED_W = 32;
  localparam int TEMPO_W   = 26;
  localparam int BAR_W     = 24;
  localparam int TIME_W    = 64;
  localparam int PHASE_W   = 24;
  localparam int PB_W      = 23;
  localparam int PS_W      = 25;

  // Beat increment: round(fwd * tempo / (60 * 2^16)) = ((fwd * tempo + bias) >> 18) / 15
  localparam int FWD_W    = ELAPSED_W - 1;
  localparam int PROD_W   = FWD_W + TEMPO_W;
  localparam int RND_SH   = 18;
  localparam int QUO_W    = PROD_W - RND_SH;
  localparam int REM15_W  = 4;
  localparam logic [PROD_W-1:0]  RND_BIAS = PROD_W'(1966080);
  localparam logic [REM15_W:0]   BEAT_DIV = 5'd15;

  // Saturation ceiling of the free-running clocks
  localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  // Half a bar in Q0.24, one bit wider for the compare
  localparam logic [BAR_W:0]    HALF_BAR = 25'h0800000;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOMAIN    = 3'd0,
    CFG_SYNC      = 3'd1,
    CFG_LOOP      = 3'd2,
    CFG_PER_BEATS = 3'd3,
    CFG_PER_SECS  = 3'd4
  } cfg_idx_t;

  // Stream word widths, padded to whole bytes
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 88;

endpackage

/* rtl/transport_beat_phase_source_top.sv */
// Top level of the transport beat phase source: registers, clocks, bar counter, result word.
//
// One input word per frame tick on in_* (tvalid/tready) carries elapsed time, tempo,
// host bar phase and host time. For each accepted word one result word leaves on out_*
// with the loop phase and the wrapped or absolute position. Registers are written on
// cfg_* (index, data), always ready, and are meant to change only while the block idles.
// A word is taken only while the block idles, so one word is worked on at a time; the
// next input word can be taken in the same cycle that the result word becomes valid.
// The bit-serial units do the work: 26 multiply steps and 39 divide-by-15 steps for the
// beat increment, 64 remainder steps and 24 phase steps in the period divider, plus
// handover states between them.
// A finished result sits in the output register; the next input word is accepted while
// it waits. If the receiver still stalls when the following result is done, that result
// is held in the divider and the input side stays not ready until the register drains.
// Reset (rst_n low, synchronous) restores the register defaults, clears the free-running
// clocks and the bar counter, and marks the bar phase unseeded: the first word after
// reset only seeds the bar phase.
module transport_beat_phase_source_top #(
  parameter int FRAC_BITS = tbps_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: elapsed[31:0], tempo[57:32], bar_position[81:58], host_seconds[145:82]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tbps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: loop_phase[23:0], position_value[87:24]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tbps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tbps_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_BEAT, ST_SEL, ST_DIV, ST_OUT} state_t;

  localparam int PER_W  = FRAC_BITS + 9;
  localparam int PER_SH = FRAC_BITS - 16;
  localparam int UP_SH  = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int DN_SH  = (FRAC_BITS >= 24) ? 0 : 24 - FRAC_BITS;
  localparam logic [PER_W-1:0] PMIN =
    PER_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  // configuration registers
  logic             dom_r;
  logic             sync_r;
  logic             loop_r;
  logic [PB_W-1:0]  per_beats_r;
  logic [PS_W-1:0]  per_secs_r;

  // accumulated state
  logic [TIME_W-1:0] free_secs_r;
  logic [TIME_W-1:0] free_beats_r;
  logic [31:0]       bar_cnt_r;
  logic [BAR_W-1:0]  last_bp_r;
  logic              seeded_r;

  // captured input word
  logic [ELAPSED_W-1:0] el_r;
  logic [BAR_W-1:0]     bp_r;
  logic [TIME_W-1:0]    host_r;

  state_t                st_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [TIME_W-1:0]     t_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic [FWD_W-1:0]      fwd;
  logic                  beat_done;
  logic [QUO_W-1:0]      beat_incr;
  logic                  div_start;
  logic                  div_done;
  logic [PER_W-1:0]      div_rem;
  logic [PHASE_W-1:0]    div_phase;
  logic [TIME_W-1:0]     secs_sum;
  logic [TIME_W-1:0]     beats_sum;
  logic                  bar_wrap;
  logic [TIME_W-1:0]     bar_frac;
  logic [TIME_W-1:0]     bar_t;
  logic [TIME_W-1:0]     t_sel;
  logic [PER_W-1:0]      per_raw;
  logic [PER_W-1:0]      per_sel;
  logic [OUT_TDATA_W-1:0] result;

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // a finished result moves into the output register once it is free
  assign out_load = out_free && ((st_r == ST_DIV && div_done) || st_r == ST_OUT);

  // negative steps count as zero
  assign fwd = el_r[ELAPSED_W-1] ? '0 : el_r[FWD_W-1:0];

  // saturating sums; the sum cannot overflow 64 bits as the clocks stay at or below the max
  assign secs_sum  = free_secs_r + TIME_W'(fwd);
  assign beats_sum = free_beats_r + TIME_W'(beat_incr);

  // bar wraps when the phase falls by more than half a bar
  assign bar_wrap = ({1'b0, bp_r} + HALF_BAR) < {1'b0, last_bp_r};

  // locked beat time: four beats per bar, wraps modulo 2^64
  assign bar_frac = ((TIME_W'(last_bp_r) << 2) << UP_SH) >> DN_SH;
  assign bar_t    = (TIME_W'(bar_cnt_r) << (FRAC_BITS + 2)) + bar_frac;

  // time source by domain and sync mode
  always_comb begin
    case ({dom_r, sync_r})
      2'b11:   t_sel = bar_t;
      2'b10:   t_sel = free_beats_r;
      2'b01:   t_sel = host_r;
      default: t_sel = free_secs_r;
    endcase
  end

  // period in time format, floored at 1e-4
  assign per_raw = dom_r ? (PER_W'(per_beats_r) << PER_SH) : (PER_W'(per_secs_r) << PER_SH);
  assign per_sel = (per_raw < PMIN) ? PMIN : per_raw;

  assign div_start = (st_r == ST_SEL);
  assign result    = {(loop_r ? TIME_W'(div_rem) : t_r), div_phase};

  tbps_beat_rate u_beat (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_acc),
    .fwd_i   (in_tdata[ELAPSED_W-2:0] & {FWD_W{~in_tdata[ELAPSED_W-1]}}),
    .tempo_i (in_tdata[ELAPSED_W +: TEMPO_W]),
    .done_o  (beat_done),
    .incr_o  (beat_incr)
  );

  tbps_mod_div #(.PER_W(PER_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .t_i     (t_sel),
    .per_i   (per_sel),
    .done_o  (div_done),
    .rem_o   (div_rem),
    .phase_o (div_phase)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dom_r       <= 1'b1;
      sync_r      <= 1'b1;
      loop_r      <= 1'b1;
      per_beats_r <= PB_W'(262144);
      per_secs_r  <= PS_W'(327680);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DOMAIN:    dom_r       <= cfg_data[0];
        CFG_SYNC:      sync_r      <= cfg_data[0];
        CFG_LOOP:      loop_r      <= cfg_data[0];
        CFG_PER_BEATS: per_beats_r <= cfg_data[PB_W-1:0];
        CFG_PER_SECS:  per_secs_r  <= cfg_data[PS_W-1:0];
        default:       ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      el_r    <= in_tdata[ELAPSED_W-1:0];
      bp_r    <= in_tdata[ELAPSED_W+TEMPO_W +: BAR_W];
      host_r  <= in_tdata[ELAPSED_W+TEMPO_W+BAR_W +: TIME_W];
    end
  end

  // clocks and bar counter advance once the beat increment is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_secs_r  <= '0;
      free_beats_r <= '0;
      bar_cnt_r    <= '0;
      last_bp_r    <= '0;
      seeded_r     <= 1'b0;
    end else if (st_r == ST_BEAT && beat_done) begin
      free_secs_r  <= secs_sum[TIME_W-1] ? TIME_MAX : secs_sum;
      free_beats_r <= beats_sum[TIME_W-1] ? TIME_MAX : beats_sum;
      if (seeded_r && bar_wrap) begin
        bar_cnt_r <= bar_cnt_r + 1'b1;
      end
      seeded_r  <= 1'b1;
      last_bp_r <= bp_r;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_data_r  <= result;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            st_r <= ST_BEAT;
          end
        end
        ST_BEAT: begin
          if (beat_done) begin
            st_r <= ST_SEL;
          end
        end
        ST_SEL: begin
          t_r  <= t_sel;
          st_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            st_r <= out_free ? ST_IDLE : ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // the free seconds clock never runs backward
  a_secs_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> free_secs_r >= $past(free_secs_r))
    else $error("free seconds went backward");
  // beat unit finishes only while the sequencer waits on it
  a_beat_done: assert property (@(posedge clk) disable iff (!rst_n)
    beat_done |-> st_r == ST_BEAT)
    else $error("beat increment arrived out of sequence");
  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == ST_DIV)
    else $error("divider result arrived out of sequence");
  // once seeded, the bar phase stays seeded until reset
  a_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(seeded_r) |-> seeded_r)
    else $error("bar phase lost its seed");
`endif

endmodule

/* rtl/tbps_beat_rate.sv */
// Bit-serial multiplier and divide-by-15 unit that turns a time step and tempo into beats.
module tbps_beat_rate (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [tbps_pkg::FWD_W-1:0]   fwd_i,
  input  logic [tbps_pkg::TEMPO_W-1:0] tempo_i,
  output logic                         done_o,
  output logic [tbps_pkg::QUO_W-1:0]   incr_o
);
  import tbps_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_RND, S_DIV} state_t;

  localparam int CNT_W = $clog2(QUO_W);

  state_t               st_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;
  logic [FWD_W-1:0]     fwd_r;
  logic [TEMPO_W-1:0]   tp_r;
  logic [PROD_W-1:0]    acc_r;
  logic [QUO_W-1:0]     q_r;
  logic [REM15_W-1:0]   rem_r;

  logic [PROD_W-1:0]    mul_sum;
  logic [PROD_W-1:0]    rnd_sum;
  logic [REM15_W:0]     trial;
  logic                 ge;
  logic [REM15_W-1:0]   rem_step;

  // Multiply MSB first: shift the product, add the multiplicand on a set tempo bit
  assign mul_sum = {acc_r[PROD_W-2:0], 1'b0} + (tp_r[TEMPO_W-1] ? PROD_W'(fwd_r) : '0);
  assign rnd_sum = acc_r + RND_BIAS;

  // Restoring divide by 15, one quotient bit per cycle
  assign trial    = {rem_r, q_r[QUO_W-1]};
  assign ge       = (trial >= BEAT_DIV);
  assign rem_step = ge ? REM15_W'(trial - BEAT_DIV) : trial[REM15_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (start_i) begin
            fwd_r <= fwd_i;
            tp_r  <= tempo_i;
            acc_r <= '0;
            cnt_r <= '0;
            st_r  <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r <= mul_sum;
          tp_r  <= {tp_r[TEMPO_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(TEMPO_W - 1)) begin
            st_r <= S_RND;
          end
        end
        S_RND: begin
          // add the half-step bias and drop the low bits
          q_r   <= rnd_sum[PROD_W-1:RND_SH];
          rem_r <= '0;
          cnt_r <= '0;
          st_r  <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_step;
          q_r   <= {q_r[QUO_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(QUO_W - 1)) begin
            done_r <= 1'b1;
            st_r   <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_r;
  assign incr_o = q_r;

`ifndef SYNTH
  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> rem_r < BEAT_DIV[REM15_W-1:0])
    else $error("divide-by-15 remainder out of range");
  // a new job only starts on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> st_r == S_IDLE)
    else $error("beat unit started while busy");
  // done follows the last quotient step
  a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_o |-> $past(st_r) == S_DIV)
    else $error("beat unit done without a divide");
`endif

endmodule

/* rtl/tbps_mod_div.sv */
// Bit-serial floor remainder of a signed time by the loop period, then the phase fraction.
module tbps_mod_div #(
  parameter int PER_W = 33
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [tbps_pkg::TIME_W-1:0]  t_i,
  input  logic [PER_W-1:0]             per_i,
  output logic                         done_o,
  output logic [PER_W-1:0]             rem_o,
  output logic [tbps_pkg::PHASE_W-1:0] phase_o
);
  import tbps_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_FIX, S_FRAC} state_t;

  localparam int CNT_W = $clog2(TIME_W);

  state_t              st_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                done_r;
  logic [TIME_W-1:0]   dvd_r;
  logic [PER_W-1:0]    per_r;
  logic [PER_W-1:0]    acc_r;
  logic [PER_W-1:0]    rem_r;
  logic [PHASE_W-1:0]  phase_r;
  logic                neg_r;

  logic [TIME_W-1:0]   t_mag;
  logic [PER_W:0]      trial;
  logic                ge;
  logic [PER_W-1:0]    acc_step;
  logic [PER_W-1:0]    fixed;

  // magnitude of the signed time; the most negative value maps to 2^63
  assign t_mag = t_i[TIME_W-1] ? (~t_i + 1'b1) : t_i;

  // one restoring step: dividend bits during the remainder pass, zeros for the phase
  assign trial    = {acc_r, (st_r == S_MOD) ? dvd_r[TIME_W-1] : 1'b0};
  assign ge       = (trial >= {1'b0, per_r});
  assign acc_step = ge ? PER_W'(trial - {1'b0, per_r}) : trial[PER_W-1:0];

  // floor correction for a negative time
  assign fixed = (neg_r && (acc_r != '0)) ? (per_r - acc_r) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (start_i) begin
            dvd_r <= t_mag;
            neg_r <= t_i[TIME_W-1];
            per_r <= per_i;
            acc_r <= '0;
            cnt_r <= '0;
            st_r  <= S_MOD;
          end
        end
        S_MOD: begin
          acc_r <= acc_step;
          dvd_r <= {dvd_r[TIME_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(TIME_W - 1)) begin
            st_r <= S_FIX;
          end
        end
        S_FIX: begin
          acc_r <= fixed;
          rem_r <= fixed;
          cnt_r <= '0;
          st_r  <= S_FRAC;
        end
        S_FRAC: begin
          acc_r   <= acc_step;
          phase_r <= {phase_r[PHASE_W-2:0], ge};
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(PHASE_W - 1)) begin
            done_r <= 1'b1;
            st_r   <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done_o  = done_r;
  assign rem_o   = rem_r;
  assign phase_o = phase_r;

`ifndef SYNTH
  // partial remainder stays below the period in both passes
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MOD || st_r == S_FRAC) |-> acc_r < per_r)
    else $error("partial remainder not below period");
  // the corrected remainder lies in [0, period)
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FRAC |-> rem_r < per_r)
    else $error("loop remainder out of range");
  // a new job only starts on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> st_r == S_IDLE)
    else $error("divider started while busy");
`endif

endmodule

/* tb/sv/tbps_checker.sv */
// Checker for the transport beat phase source: tracks registers, predicts result words, compares.
`timescale 1ns / 100ps

module tbps_checker #(
  parameter int FRAC_BITS = tbps_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tbps_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tbps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import tbps_pkg::*;

  // Result word as laid out on out_tdata (loop_phase in the low bits)
  typedef struct packed {
    logic [TIME_W-1:0]  position_value;
    logic [PHASE_W-1:0] loop_phase;
  } phase_word_t;

  // Register copy
  bit              dom_beats;
  bit              host_locked;
  bit              wrap_loop;
  logic [PB_W-1:0] per_beats;
  logic [PS_W-1:0] per_secs;

  // Clock state copy
  logic [TIME_W-1:0] free_secs;
  logic [TIME_W-1:0] free_beats;
  logic [31:0]       bar_count;
  logic [BAR_W-1:0]  last_bar;
  bit                bar_seeded;

  phase_word_t expected_words[$];

  function automatic logic [TIME_W-1:0] clamp_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    if (a >= TIME_MAX || b > TIME_MAX - a) return TIME_MAX;
    return a + b;
  endfunction

  // One frame tick: advance the clocks and bar counter, then derive phase and position
  function automatic phase_word_t advance_tick(logic [ELAPSED_W-1:0] elapsed,
                                               logic [TEMPO_W-1:0] tempo,
                                               logic [BAR_W-1:0] bar_pos,
                                               logic [TIME_W-1:0] host_t);
    logic [63:0]        fwd;
    logic [63:0]        beat_step;
    logic [63:0]        bar_q24;
    logic [TIME_W-1:0]  t;
    logic [63:0]        per;
    logic [63:0]        per_floor;
    logic [63:0]        acc;
    longint             ts;
    longint             r;
    logic [PHASE_W-1:0] ph;
    phase_word_t        res;

    // negative steps count as zero
    fwd = elapsed[ELAPSED_W-1] ? 64'd0 : 64'(elapsed);
    free_secs = clamp_add(free_secs, fwd);
    beat_step = (fwd * 64'(tempo) + 64'd1966080) / 64'd3932160;
    free_beats = clamp_add(free_beats, beat_step);

    // bar counter steps when the host phase falls by more than half a bar
    if (!bar_seeded) begin
      bar_seeded = 1'b1;
    end else if ({1'b0, bar_pos} + HALF_BAR < {1'b0, last_bar}) begin
      bar_count = bar_count + 32'd1;
    end
    last_bar = bar_pos;

    if (dom_beats) begin
      bar_q24 = {38'd0, last_bar, 2'b00};
      if (FRAC_BITS >= 24) bar_q24 = bar_q24 << (FRAC_BITS - 24);
      else bar_q24 = bar_q24 >> (24 - FRAC_BITS);
      t = host_locked ? (64'(bar_count) << (FRAC_BITS + 2)) + bar_q24 : free_beats;
    end else begin
      t = host_locked ? host_t : free_secs;
    end

    // active period in time format, never below 1e-4
    per = dom_beats ? 64'(per_beats) : 64'(per_secs);
    per = per << (FRAC_BITS - 16);
    per_floor = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
    if (per_floor == 64'd0) per_floor = 64'd1;
    if (per < per_floor) per = per_floor;

    // floor remainder, then 24 quotient bits of rem / per
    ts = t;
    r = ts % longint'(per);
    if (r < 0) r = r + longint'(per);
    acc = r;
    ph = '0;
    for (int i = 0; i < PHASE_W; i++) begin
      acc = acc << 1;
      ph = ph << 1;
      if (acc >= per) begin
        acc = acc - per;
        ph[0] = 1'b1;
      end
    end

    res.loop_phase = ph;
    res.position_value = wrap_loop ? 64'(r) : t;
    return res;
  endfunction

  task automatic log_failure(string msg);
    if (fail_count < 10) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // Sample all three channels on the rising edge
  always @(posedge clk) begin : watch
    phase_word_t got;
    phase_word_t want;
    if (!rst_n) begin
      dom_beats   = 1'b1;
      host_locked = 1'b1;
      wrap_loop   = 1'b1;
      per_beats   = PB_W'(262144);
      per_secs    = PS_W'(327680);
      free_secs   = '0;
      free_beats  = '0;
      bar_count   = '0;
      last_bar    = '0;
      bar_seeded  = 1'b0;
      fail_count  = 0;
      expected_words.delete();
    end else begin
      // result words first: a word accepted this edge cannot be answered yet
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_words.size() == 0) begin
          log_failure($sformatf("unexpected word: loop_phase %h position_value %h",
                                got.loop_phase, got.position_value));
        end else begin
          want = expected_words.pop_front();
          if (got.loop_phase !== want.loop_phase)
            log_failure($sformatf("loop_phase expected %h got %h",
                                  want.loop_phase, got.loop_phase));
          if (got.position_value !== want.position_value)
            log_failure($sformatf("position_value expected %h got %h",
                                  want.position_value, got.position_value));
        end
      end

      if (in_tvalid && in_tready)
        expected_words.push_back(advance_tick(
          in_tdata[ELAPSED_W-1:0],
          in_tdata[ELAPSED_W +: TEMPO_W],
          in_tdata[ELAPSED_W + TEMPO_W +: BAR_W],
          in_tdata[ELAPSED_W + TEMPO_W + BAR_W +: TIME_W]));

      // register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DOMAIN:    dom_beats   = cfg_data[0];
          CFG_SYNC:      host_locked = cfg_data[0];
          CFG_LOOP:      wrap_loop   = cfg_data[0];
          CFG_PER_BEATS: per_beats   = cfg_data[PB_W-1:0];
          CFG_PER_SECS:  per_secs    = cfg_data[PS_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_words.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the transport beat phase source: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import tbps_pkg::*;

  localparam int ITEMS_PER_PHASE = 140;
  localparam int DRAIN_CYCLES    = 320;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending;

  // no idling on either side while set
  bit quiet_stretch = 1'b0;
  int stall_left = 0;

  // host transport model for well-formed frame sequences
  longint           host_clock = 0;
  logic [BAR_W-1:0] bar_clock = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  transport_beat_phase_source_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tbps_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: short random stalls plus rare long ones that can outlast a whole tick
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (quiet_stretch) begin
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 9999) < 1) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(100, 400);
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 15);
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_tick(logic [ELAPSED_W-1:0] elapsed,
                                                      logic [TEMPO_W-1:0] tempo,
                                                      logic [BAR_W-1:0] bar_pos,
                                                      logic [TIME_W-1:0] host_t);
    return {6'd0, host_t, bar_pos, tempo, elapsed};
  endfunction

  // Mostly plausible frame ticks, with some noise and full-range values mixed in
  function automatic logic [IN_TDATA_W-1:0] random_tick();
    logic [ELAPSED_W-1:0] elapsed;
    logic [TEMPO_W-1:0]   tempo;
    logic [BAR_W-1:0]     bar_pos;
    logic [TIME_W-1:0]    host_t;
    int                   sel;

    sel = $urandom_range(0, 99);
    if (sel < 70)      elapsed = $urandom_range(0, 1 << 25);
    else if (sel < 80) elapsed = {1'b1, 31'($urandom)};
    else if (sel < 90) elapsed = $urandom;
    else begin
      case ($urandom_range(0, 3))
        0:       elapsed = 32'h0000_0000;
        1:       elapsed = 32'h7FFF_FFFF;
        2:       elapsed = 32'h8000_0000;
        default: elapsed = 32'hFFFF_FFFF;
      endcase
    end

    sel = $urandom_range(0, 99);
    if (sel < 75)      tempo = TEMPO_W'($urandom_range(40 << 16, 300 << 16));
    else if (sel < 85) tempo = TEMPO_W'($urandom_range(0, 65536000));
    else if (sel < 95) tempo = 26'($urandom);
    else begin
      case ($urandom_range(0, 2))
        0:       tempo = '0;
        1:       tempo = 26'd65536000;
        default: tempo = '1;
      endcase
    end

    // bar phase advances and wraps; sometimes jumps anywhere
    sel = $urandom_range(0, 99);
    if (sel < 85) bar_clock = bar_clock + BAR_W'($urandom_range(0, 1 << 21));
    else          bar_clock = BAR_W'($urandom);
    bar_pos = bar_clock;

    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      if (!elapsed[ELAPSED_W-1]) host_clock = host_clock + longint'(elapsed);
    end else if (sel < 90) begin
      host_clock = {$urandom, $urandom};
    end else begin
      host_clock = -longint'($urandom_range(0, 1 << 30));
    end
    host_t = host_clock;

    return pack_tick(elapsed, tempo, bar_pos, host_t);
  endfunction

  // Entered and left at a falling edge; tvalid stays high into the next word
  task automatic put_tick(logic [IN_TDATA_W-1:0] word);
    if (!quiet_stretch && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 170)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // cfg_valid stays high across a group of writes; the caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One setting: write every register (flags with junk upper bits), then random ticks
  task automatic run_phase(bit dom, bit sync, bit wrap, logic [CFG_DATA_W-1:0] pb,
                           logic [CFG_DATA_W-1:0] ps, bit quiet);
    wait_idle();
    write_reg(CFG_DOMAIN, {24'($urandom), dom});
    write_reg(CFG_SYNC, {24'($urandom), sync});
    write_reg(CFG_IDX_W'($urandom_range(int'(CFG_PER_SECS) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    write_reg(CFG_LOOP, {24'($urandom), wrap});
    write_reg(CFG_PER_BEATS, pb);
    write_reg(CFG_PER_SECS, ps);
    cfg_valid <= 1'b0;
    quiet_stretch <= quiet;
    repeat (ITEMS_PER_PHASE) put_tick(random_tick());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks at the reset setting (beats, locked, wrapped)
    put_tick(pack_tick(32'd279620, 26'd7864320, 24'hC00000, 64'd0));          // seeds only
    put_tick(pack_tick(32'd279620, 26'd7864320, 24'hFFFFFF, 64'd16777216));
    put_tick(pack_tick(32'h7FFF_FFFF, 26'd65536000, 24'h000000, 64'h7FFF_FFFF_FFFF_FFFF));
    put_tick(pack_tick(32'h8000_0000, 26'h3FF_FFFF, 24'h7FFFFF, 64'h8000_0000_0000_0000));
    put_tick(pack_tick(32'hFFFF_FFFF, 26'd0, 24'h800000, 64'hFFFF_FFFF_FFFF_FFFF));
    put_tick(pack_tick(32'd0, 26'd7864320, 24'h000000, 64'd0));      // drop of exactly half
    put_tick(pack_tick(32'd1, 26'd1, 24'hFFFFFF, 64'd1));
    put_tick(pack_tick(32'd279620, 26'd7864320, 24'h7FFFFE, 64'd2)); // just over half
    put_tick(pack_tick(32'h7FFF_FFFF, 26'h3FF_FFFF, 24'h123456, 64'hFFFF_FFFF_FFFF_FFFF));
    put_tick(pack_tick(32'h7FFF_FFFF, 26'h3FF_FFFF, 24'h654321, 64'h0123_4567_89AB_CDEF));
    put_tick(pack_tick(32'hAAAA_AAAA, 26'h2AA_AAAA, 24'hAAAAAA, 64'hAAAA_AAAA_AAAA_AAAA));
    put_tick(pack_tick(32'h5555_5555, 26'h155_5555, 24'h555555, 64'h5555_5555_5555_5555));
    put_tick(pack_tick(32'd16777216, 26'd7864320, 24'h000001, 64'hFFFF_FFFF_FF00_0000));

    // Register settings, extremes first
    run_phase(1'b1, 1'b0, 1'b1, 25'd16384, 25'd3277, 1'b0);
    run_phase(1'b1, 1'b0, 1'b0, 25'd4194304, 25'd19660800, 1'b0);
    run_phase(1'b0, 1'b1, 1'b1, 25'd262144, 25'd3277, 1'b1);
    run_phase(1'b0, 1'b1, 1'b0, 25'd262144, 25'd19660800, 1'b0);
    run_phase(1'b0, 1'b0, 1'b1, 25'd0, 25'd0, 1'b0);                 // period floor
    run_phase(1'b0, 1'b0, 1'b0, 25'd262144, 25'd327680, 1'b0);
    run_phase(1'b1, 1'b1, 1'b0, 25'h7FFFFF, 25'h1FFFFFF, 1'b0);
    run_phase(1'b1, 1'b1, 1'b1, 25'h1FFFFFF, 25'd1, 1'b0);           // upper bits masked
    run_phase(1'b0, 1'b1, 1'b1, 25'd1, 25'h1FFFFFF, 1'b0);
    run_phase(1'b1, 1'b0, 1'b1, CFG_DATA_W'($urandom_range(16384, 4194304)),
              CFG_DATA_W'($urandom_range(3277, 19660800)), 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
